// File: hw/rtl/rwa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rwa_pkg;

    localparam int RING_SLOTS = 60;
    localparam int SLOT_W     = 6;
    localparam int RAIN_W     = 10;
    localparam int HOUR_W     = 5;
    localparam int SUM_W      = 16;
    localparam int STAMP_W    = 12;
    localparam int TEN_W      = 14;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SLOT_W-1:0]  LAST_SLOT   = SLOT_W'(RING_SLOTS - 1);
    localparam logic [HOUR_W-1:0]  CLEAR_HOUR  = HOUR_W'(20);
    localparam logic [STAMP_W-1:0] STAMP_SCALE = STAMP_W'(100);
    localparam logic [SUM_W:0]     SUM_MAX     = (SUM_W+1)'(RING_SLOTS * 1023);

    localparam logic [CFG_IDX_W-1:0] REG_HOUR_THR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DAY_THR  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ALU_ADD = 2'b01,
        ALU_SUB = 2'b10
    } alu_op_t;

    typedef struct packed {
        logic               flag;
        logic [STAMP_W-1:0] stamp;
    } alarm_stat_t;

    typedef struct packed {
        logic [TEN_W-1:0]   sum_ten;
        logic [SUM_W-1:0]   sum_sixty;
        logic [SUM_W-1:0]   peak_sixty;
        logic [STAMP_W-1:0] peak_time;
        logic [STAMP_W-1:0] hour_alarm_time;
        logic [STAMP_W-1:0] day_alarm_time;
        logic               hour_alarm;
        logic               day_alarm;
        logic [SUM_W-1:0]   day_total;
    } out_word_t;

endpackage

`default_nettype wire

// File: hw/rtl/rwa_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rwa_in_if;
    logic                       valid;
    logic                       ready;
    logic [rwa_pkg::RAIN_W-1:0] minute_rain;
    logic [rwa_pkg::HOUR_W-1:0] clock_hour;
    logic [rwa_pkg::SLOT_W-1:0] clock_minute;

    modport source (output valid, minute_rain, clock_hour, clock_minute, input ready);
    modport sink   (input valid, minute_rain, clock_hour, clock_minute, output ready);
endinterface

interface rwa_out_if;
    logic                        valid;
    logic                        ready;
    logic [rwa_pkg::TEN_W-1:0]   sum_ten;
    logic [rwa_pkg::SUM_W-1:0]   sum_sixty;
    logic [rwa_pkg::SUM_W-1:0]   peak_sixty;
    logic [rwa_pkg::STAMP_W-1:0] peak_time;
    logic [rwa_pkg::STAMP_W-1:0] hour_alarm_time;
    logic [rwa_pkg::STAMP_W-1:0] day_alarm_time;
    logic                        hour_alarm;
    logic                        day_alarm;
    logic                        buzzer_on;
    logic [rwa_pkg::SUM_W-1:0]   day_total;

    modport source (output valid, sum_ten, sum_sixty, peak_sixty, peak_time,
                    hour_alarm_time, day_alarm_time, hour_alarm, day_alarm,
                    buzzer_on, day_total, input ready);
    modport sink   (input valid, sum_ten, sum_sixty, peak_sixty, peak_time,
                    hour_alarm_time, day_alarm_time, hour_alarm, day_alarm,
                    buzzer_on, day_total, output ready);
endinterface

interface rwa_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rwa_pkg::CFG_IDX_W-1:0] index;
    logic [rwa_pkg::SUM_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rwa_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module rwa_ring
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [rwa_pkg::SLOT_W-1:0] wr_addr,
    input  wire logic [rwa_pkg::RAIN_W-1:0] wr_data,
    input  wire logic [rwa_pkg::SLOT_W-1:0] rd_addr,
    output logic      [rwa_pkg::RAIN_W-1:0] rd_data
);

    logic [rwa_pkg::RAIN_W-1:0]     mem [rwa_pkg::RING_SLOTS];
    logic [rwa_pkg::RING_SLOTS-1:0] valid_reg;
    logic [rwa_pkg::RAIN_W-1:0]     mem_rd_reg;
    logic                           vld_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_rd_reg <= mem[rd_addr];
    end

    // slot never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            vld_rd_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = vld_rd_reg ? mem_rd_reg : '0;

endmodule

`default_nettype wire

// File: hw/rtl/rwa_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module rwa_alu
(
    input  wire rwa_pkg::alu_op_t          op,
    input  wire logic [rwa_pkg::SUM_W-1:0] a,
    input  wire logic [rwa_pkg::SUM_W-1:0] b,
    output logic      [rwa_pkg::SUM_W:0]   result
);

    always_comb
    begin
        unique case (op)
            rwa_pkg::ALU_ADD: result = {1'b0, a} + {1'b0, b};
            rwa_pkg::ALU_SUB: result = {1'b0, a} - {1'b0, b};
            default:          result = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/rwa_alarm.sv
`timescale 1ns / 1ps
`default_nettype none

module rwa_alarm
#(
    parameter int HOLD_MINUTES = 20
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic                        hit,
    input  wire logic [rwa_pkg::STAMP_W-1:0] stamp,
    output rwa_pkg::alarm_stat_t             stat
);

    localparam int CNT_W = $clog2(HOLD_MINUTES + 2);

    logic                        flag_reg, flag_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [rwa_pkg::STAMP_W-1:0] stamp_reg, stamp_next;

    // a trigger restarts the hold; flag drops once the count passes the hold time
    always_comb
    begin
        flag_next  = flag_reg;
        cnt_next   = cnt_reg;
        stamp_next = stamp_reg;
        if (step)
        begin
            if (hit)
            begin
                flag_next  = 1'b1;
                cnt_next   = '0;
                stamp_next = stamp;
            end
            if (flag_next)
            begin
                cnt_next = cnt_next + CNT_W'(1);
                if (cnt_next > CNT_W'(HOLD_MINUTES))
                begin
                    flag_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg  <= 1'b0;
            cnt_reg   <= '0;
            stamp_reg <= '0;
        end
        else
        begin
            flag_reg  <= flag_next;
            cnt_reg   <= cnt_next;
            stamp_reg <= stamp_next;
        end
    end

    assign stat.flag  = flag_reg;
    assign stat.stamp = stamp_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rain_window_alarm_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake     payload
// in_ch     in   valid/ready   minute_rain, clock_hour, clock_minute
// out_ch    out  valid/ready   sums, peak, alarm stamps and flags, day_total
// cfg_ch    in   valid/ready   index, data (threshold writes)
//
// Each accepted minute runs S_OLD, S_ADD, S_DAY, S_WALK, S_DRAIN, S_DONE, S_PUT before the next accept:
// the SHORT_SPAN-slot window (10 at default) is walked one ring read per cycle through a single adder.
// in_ch.ready is high only while the sequencer is idle; cfg_ch.ready is always high.
// Reset clears the ring through per-slot valid bits at once: no clearing pass.
// A stalled out_ch holds the last result; the next word waits in the final step.

module rain_window_alarm_top
#(
    parameter int SHORT_SPAN   = 10,
    parameter int HOLD_MINUTES = 20
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rwa_in_if.sink     in_ch,
    rwa_out_if.source  out_ch,
    rwa_cfg_if.sink    cfg_ch
);

    localparam int WALK_W = $clog2(SHORT_SPAN + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_OLD   = 8'b0000_0010,
        S_ADD   = 8'b0000_0100,
        S_DAY   = 8'b0000_1000,
        S_WALK  = 8'b0001_0000,
        S_DRAIN = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_PUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [rwa_pkg::SUM_W-1:0]   hour_thr_reg, day_thr_reg;
    logic [rwa_pkg::RAIN_W-1:0]  rain_reg, rain_next;
    logic [rwa_pkg::HOUR_W-1:0]  hour_reg, hour_next;
    logic [rwa_pkg::SLOT_W-1:0]  minute_reg, minute_next;
    logic [rwa_pkg::STAMP_W-1:0] stamp_reg, stamp_next;
    logic [rwa_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [WALK_W-1:0]           walk_reg, walk_next;
    logic                        pend_reg, pend_next;
    logic [rwa_pkg::SUM_W-1:0]   sum10_reg, sum10_next;
    logic [rwa_pkg::SUM_W-1:0]   sum60_reg, sum60_next;
    logic [rwa_pkg::SUM_W-1:0]   day_reg, day_next;
    logic [rwa_pkg::SUM_W-1:0]   peak_reg, peak_next;
    logic [rwa_pkg::STAMP_W-1:0] peak_stamp_reg, peak_stamp_next;
    logic                        out_valid_reg, out_valid_next;
    rwa_pkg::out_word_t          out_reg, out_next;

    logic                        in_fire, out_free, alarm_step;
    logic [rwa_pkg::SLOT_W-1:0]  in_minute;
    logic [rwa_pkg::SLOT_W-1:0]  rd_addr;
    logic [rwa_pkg::RAIN_W-1:0]  rd_data;
    logic                        wr_en;
    rwa_pkg::alu_op_t            alu_op;
    logic [rwa_pkg::SUM_W-1:0]   alu_a, alu_b;
    logic [rwa_pkg::SUM_W:0]     alu_res;
    rwa_pkg::alarm_stat_t        hour_stat, day_stat;

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign in_minute = (in_ch.clock_minute > rwa_pkg::LAST_SLOT) ? rwa_pkg::LAST_SLOT
                                                                 : in_ch.clock_minute;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_thr_reg <= '1;
            day_thr_reg  <= '1;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            unique case (cfg_ch.index)
                rwa_pkg::REG_HOUR_THR: hour_thr_reg <= cfg_ch.data;
                rwa_pkg::REG_DAY_THR:  day_thr_reg  <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    assign rd_addr = (state_reg == S_IDLE) ? in_minute : slot_reg;
    assign wr_en   = (state_reg == S_OLD);

    rwa_ring u_ring
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (minute_reg),
        .wr_data (rain_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared adder operand routing
    always_comb
    begin
        alu_op = rwa_pkg::ALU_ADD;
        alu_a  = sum10_reg;
        alu_b  = rwa_pkg::SUM_W'(rd_data);
        unique case (state_reg)
            S_OLD:
            begin
                alu_op = rwa_pkg::ALU_SUB;
                alu_a  = sum60_reg;
            end
            S_ADD:
            begin
                alu_a = sum60_reg;
                alu_b = rwa_pkg::SUM_W'(rain_reg);
            end
            S_DAY:
            begin
                alu_a = day_reg;
                alu_b = rwa_pkg::SUM_W'(rain_reg);
            end
            default: ;
        endcase
    end

    rwa_alu u_alu
    (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res)
    );

    assign alarm_step = (state_reg == S_DONE);

    rwa_alarm #(.HOLD_MINUTES(HOLD_MINUTES)) u_hour_alarm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (alarm_step),
        .hit   (sum60_reg >= hour_thr_reg),
        .stamp (stamp_reg),
        .stat  (hour_stat)
    );

    rwa_alarm #(.HOLD_MINUTES(HOLD_MINUTES)) u_day_alarm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (alarm_step),
        .hit   (day_reg >= day_thr_reg),
        .stamp (stamp_reg),
        .stat  (day_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        rain_next       = rain_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        stamp_next      = stamp_reg;
        slot_next       = slot_reg;
        walk_next       = walk_reg;
        pend_next       = pend_reg;
        sum10_next      = sum10_reg;
        sum60_next      = sum60_reg;
        day_next        = day_reg;
        peak_next       = peak_reg;
        peak_stamp_next = peak_stamp_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    rain_next   = in_ch.minute_rain;
                    hour_next   = in_ch.clock_hour;
                    minute_next = in_minute;
                    stamp_next  = rwa_pkg::STAMP_W'(in_ch.clock_hour) * rwa_pkg::STAMP_SCALE
                                  + rwa_pkg::STAMP_W'(in_minute);
                    state_next  = S_OLD;
                end
            end
            S_OLD:
            begin
                // drop the old slot contents from the running hour sum
                sum60_next = alu_res[rwa_pkg::SUM_W-1:0];
                state_next = S_ADD;
            end
            S_ADD:
            begin
                sum60_next = alu_res[rwa_pkg::SUM_W-1:0];
                state_next = S_DAY;
            end
            S_DAY:
            begin
                day_next   = alu_res[rwa_pkg::SUM_W] ? '1 : alu_res[rwa_pkg::SUM_W-1:0];
                slot_next  = minute_reg;
                walk_next  = '0;
                pend_next  = 1'b0;
                sum10_next = '0;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (pend_reg)
                begin
                    sum10_next = alu_res[rwa_pkg::SUM_W-1:0];
                end
                pend_next = 1'b1;
                slot_next = (slot_reg == '0) ? rwa_pkg::LAST_SLOT
                                             : slot_reg - rwa_pkg::SLOT_W'(1);
                walk_next = walk_reg + WALK_W'(1);
                if (walk_reg == WALK_W'(SHORT_SPAN - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                sum10_next = alu_res[rwa_pkg::SUM_W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sum60_reg > peak_reg)
                begin
                    peak_next       = sum60_reg;
                    peak_stamp_next = stamp_reg;
                end
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    out_next.sum_ten         = sum10_reg[rwa_pkg::TEN_W-1:0];
                    out_next.sum_sixty       = sum60_reg;
                    out_next.peak_sixty      = peak_reg;
                    out_next.peak_time       = peak_stamp_reg;
                    out_next.hour_alarm_time = hour_stat.stamp;
                    out_next.day_alarm_time  = day_stat.stamp;
                    out_next.hour_alarm      = hour_stat.flag;
                    out_next.day_alarm       = day_stat.flag;
                    out_next.day_total       = day_reg;
                    out_valid_next           = 1'b1;
                    if (hour_reg == rwa_pkg::CLEAR_HOUR && minute_reg == '0)
                    begin
                        day_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            walk_reg       <= '0;
            pend_reg       <= 1'b0;
            sum60_reg      <= '0;
            day_reg        <= '0;
            peak_reg       <= '0;
            peak_stamp_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            walk_reg       <= walk_next;
            pend_reg       <= pend_next;
            sum60_reg      <= sum60_next;
            day_reg        <= day_next;
            peak_reg       <= peak_next;
            peak_stamp_reg <= peak_stamp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rain_reg   <= rain_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        stamp_reg  <= stamp_next;
        slot_reg   <= slot_next;
        sum10_reg  <= sum10_next;
        out_reg    <= out_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.sum_ten         = out_reg.sum_ten;
    assign out_ch.sum_sixty       = out_reg.sum_sixty;
    assign out_ch.peak_sixty      = out_reg.peak_sixty;
    assign out_ch.peak_time       = out_reg.peak_time;
    assign out_ch.hour_alarm_time = out_reg.hour_alarm_time;
    assign out_ch.day_alarm_time  = out_reg.day_alarm_time;
    assign out_ch.hour_alarm      = out_reg.hour_alarm;
    assign out_ch.day_alarm       = out_reg.day_alarm;
    assign out_ch.buzzer_on       = out_reg.hour_alarm || out_reg.day_alarm;
    assign out_ch.day_total       = out_reg.day_total;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ch.ready)
        else $error("input accepted while sequencer busy");

    a_sum60_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, sum60_reg} <= rwa_pkg::SUM_MAX)
        else $error("running hour sum out of range");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        walk_reg <= WALK_W'(SHORT_SPAN))
        else $error("window walk overran");

    a_alarm_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hour_stat.flag) || $rose(day_stat.flag) |-> $past(state_reg == S_DONE))
        else $error("alarm set outside update step");

    a_put_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) && out_free |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("result not loaded");

endmodule

`default_nettype wire
